// ===== hdl/flow_hash_linear_probe_table_defines.svh =====
// Assertion macros for the flow hash table.
// Used by the top level only; no other dependencies.
`ifndef FLOW_HASH_LINEAR_PROBE_TABLE_DEFINES_SVH
`define FLOW_HASH_LINEAR_PROBE_TABLE_DEFINES_SVH

`ifndef SYNTH
`define FHLP_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FHLP_ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FHLP_ASSERT(label, prop, msg)
`define FHLP_ASSERT_ALWAYS(label, prop, msg)
`endif

`endif

// ===== hdl/fhlp_pkg.sv =====
// Shared types and constants for the flow hash table.
// No dependencies; used by fhlp_store and the top level.
package fhlp_pkg;

    // SLOT_COUNT must be a power of two: the home slot is the low hash bits.
    localparam int SLOT_COUNT  = 1024;
    localparam int SLOT_BITS   = $clog2(SLOT_COUNT);
    localparam int PROBE_CNT_W = $clog2(SLOT_COUNT + 2);

    localparam int SLOT_IDX_W  = 10;
    localparam int PROBE_W     = 11;

    localparam logic [31:0] MIX_MUL   = 32'h045d_9f3b;
    localparam int          MIX_SHIFT = 16;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    typedef logic [SLOT_BITS-1:0] slot_t;

    typedef enum logic [1:0] {
        STATUS_OK      = 2'd0,
        STATUS_MISS    = 2'd1,
        STATUS_FULL    = 2'd2,
        STATUS_INVALID = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MIX,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic [15:0] dport;
        logic [15:0] sport;
        logic [31:0] dst_addr;
        logic [31:0] src_addr;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        slot_t  wr_addr;
        entry_t wr_data;
        slot_t  rd_addr;
    } store_req_t;

endpackage

// ===== hdl/flow_hash_linear_probe_table.sv =====
// Channel  Fields (low bit up)                                     Accepted when
// s_axis   tuser: op; tdata: src addr, dst addr, src port, dst port   s_tvalid & s_tready
// m_axis   tuser: status; tdata: slot_index, probe_count, zero pad    m_tvalid & m_tready
//
// After reset the store is cleared one slot per cycle, all SLOT_COUNT slots, with s_tready low.
// An item is hash-mixed through one shared 32x32 multiplier, then each slot visited takes
// a store read and then a compare, and the result is handed off in a final step.
// An invalid insert goes straight to the hand-off. The result waits in an output register
// while the next item is hashed; a stalled result holds the sequencer only at its final step.
// Depends on fhlp_pkg, fhlp_store and flow_hash_linear_probe_table_defines.svh.
`include "flow_hash_linear_probe_table_defines.svh"

module flow_hash_linear_probe_table (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    // source_address [31:0], dest_address [63:32], source_port [79:64], dest_port [95:80]
    input  logic [95:0] s_tdata,
    // op [0]
    input  logic        s_tuser,
    output logic        m_tvalid,
    input  logic        m_tready,
    // slot_index [9:0], probe_count [20:10], zero [23:21]
    output logic [23:0] m_tdata,
    // status [1:0]
    output logic [1:0]  m_tuser
);
    import fhlp_pkg::*;

    state_t                 state_reg, state_next;
    slot_t                  clr_addr_reg, clr_addr_next;
    logic                   mix_cnt_reg, mix_cnt_next;
    logic [31:0]            hash_reg, hash_next;
    entry_t                 key_reg, key_next;
    logic                   op_reg, op_next;
    slot_t                  slot_reg, slot_next;
    logic [PROBE_CNT_W-1:0] probe_cnt_reg, probe_cnt_next;
    status_t                res_status_reg, res_status_next;
    slot_t                  res_slot_reg, res_slot_next;

    logic                   m_tvalid_reg, m_tvalid_next;
    status_t                out_status_reg, out_status_next;
    logic [SLOT_IDX_W-1:0]  out_slot_reg, out_slot_next;
    logic [PROBE_W-1:0]     out_probe_reg, out_probe_next;

    store_req_t             store_req;
    entry_t                 rd_data;
    entry_t                 in_key;
    logic [31:0]            mix_in;
    logic [31:0]            mix_prod;
    logic [31:0]            mix_final;
    logic [PROBE_CNT_W-1:0] probe_inc;
    logic                   s_accept;

    fhlp_store u_store (
        .clk     (clk),
        .req     (store_req),
        .rd_data (rd_data)
    );

    assign in_key.src_addr = s_tdata[31:0];
    assign in_key.dst_addr = s_tdata[63:32];
    assign in_key.sport    = s_tdata[79:64];
    assign in_key.dport    = s_tdata[95:80];

    assign s_tready = (state_reg == ST_IDLE);
    assign s_accept = s_tvalid && s_tready;

    assign mix_in    = hash_reg ^ (hash_reg >> MIX_SHIFT);
    assign mix_prod  = mix_in * MIX_MUL;
    assign mix_final = mix_prod ^ (mix_prod >> MIX_SHIFT);
    assign probe_inc = probe_cnt_reg + 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_addr_reg  <= '0;
            mix_cnt_reg   <= 1'b0;
            probe_cnt_reg <= '0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_addr_reg  <= clr_addr_next;
            mix_cnt_reg   <= mix_cnt_next;
            probe_cnt_reg <= probe_cnt_next;
            m_tvalid_reg  <= m_tvalid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hash_reg       <= hash_next;
        key_reg        <= key_next;
        op_reg         <= op_next;
        slot_reg       <= slot_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_probe_reg  <= out_probe_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        clr_addr_next   = clr_addr_reg;
        mix_cnt_next    = mix_cnt_reg;
        hash_next       = hash_reg;
        key_next        = key_reg;
        op_next         = op_reg;
        slot_next       = slot_reg;
        probe_cnt_next  = probe_cnt_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        m_tvalid_next   = m_tvalid_reg && !m_tready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_probe_next  = out_probe_reg;

        store_req.wr_en   = 1'b0;
        store_req.wr_addr = slot_reg;
        store_req.wr_data = key_reg;
        store_req.rd_addr = slot_reg;

        case (state_reg)
            ST_CLEAR:
            begin
                store_req.wr_en   = 1'b1;
                store_req.wr_addr = clr_addr_reg;
                store_req.wr_data = '0;
                clr_addr_next     = clr_addr_reg + 1'b1;
                if (clr_addr_reg == slot_t'(SLOT_COUNT - 1))
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    key_next       = in_key;
                    op_next        = s_tuser;
                    hash_next      = in_key.src_addr ^ in_key.dst_addr ^
                                     {in_key.sport, 16'h0000} ^ {16'h0000, in_key.dport};
                    mix_cnt_next   = 1'b0;
                    probe_cnt_next = '0;
                    res_slot_next  = '0;
                    if (s_tuser == OP_INSERT && in_key.sport == 16'h0000)
                    begin
                        res_status_next = STATUS_INVALID;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        res_status_next = (s_tuser == OP_LOOKUP) ? STATUS_MISS : STATUS_FULL;
                        state_next      = ST_MIX;
                    end
                end
            end
            ST_MIX:
            begin
                hash_next    = mix_prod;
                mix_cnt_next = 1'b1;
                if (mix_cnt_reg)
                begin
                    slot_next  = mix_final[SLOT_BITS-1:0];
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_CHECK;
            end
            ST_CHECK:
            begin
                if (rd_data.sport == 16'h0000)
                begin
                    if (op_reg == OP_INSERT)
                    begin
                        store_req.wr_en = 1'b1;
                        res_status_next = STATUS_OK;
                        res_slot_next   = slot_reg;
                    end
                    state_next = ST_DONE;
                end
                else
                begin
                    probe_cnt_next = probe_inc;
                    if (op_reg == OP_LOOKUP && rd_data == key_reg)
                    begin
                        res_status_next = STATUS_OK;
                        res_slot_next   = slot_reg;
                        state_next      = ST_DONE;
                    end
                    else
                    begin
                        slot_next = slot_reg + 1'b1;
                        if (probe_inc > PROBE_CNT_W'(SLOT_COUNT))
                        begin
                            state_next = ST_DONE;
                        end
                        else
                        begin
                            state_next = ST_READ;
                        end
                    end
                end
            end
            ST_DONE:
            begin
                if (!m_tvalid_reg || m_tready)
                begin
                    m_tvalid_next   = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = SLOT_IDX_W'(res_slot_reg);
                    out_probe_next  = PROBE_W'(probe_cnt_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_status_reg;
    assign m_tdata  = {3'b000, out_probe_reg, out_slot_reg};

    `FHLP_ASSERT(a_accept_leaves_idle, s_accept |=> state_reg != ST_IDLE, "accepted item did not start work")
    `FHLP_ASSERT(a_write_only_clear_or_insert, store_req.wr_en |-> (state_reg == ST_CLEAR || (state_reg == ST_CHECK && op_reg == OP_INSERT)), "store written outside clear or insert")
    `FHLP_ASSERT(a_probe_bound, probe_cnt_reg <= PROBE_CNT_W'(SLOT_COUNT + 1), "probe count beyond limit")
    `FHLP_ASSERT(a_result_from_done, $rose(m_tvalid_reg) |-> $past(state_reg) == ST_DONE, "result raised outside final step")

endmodule

// ===== hdl/fhlp_store.sv =====
// Flow entry store: one write port and one registered read port.
// Depends on fhlp_pkg for the slot and entry types.
module fhlp_store (
    input  logic                clk,
    input  fhlp_pkg::store_req_t req,
    output fhlp_pkg::entry_t     rd_data
);
    import fhlp_pkg::*;

    entry_t mem [SLOT_COUNT];
    entry_t rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (req.wr_en)
        begin
            mem[req.wr_addr] <= req.wr_data;
        end
        rd_data_reg <= mem[req.rd_addr];
    end

    assign rd_data = rd_data_reg;

endmodule
